### design/lfr_pkg.sv
// ---------------------------------------------------------------------------
// lfr_pkg
// Shared constants, command and register codes, and controller state type
// for the linear fade ramp.
// ---------------------------------------------------------------------------
package lfr_pkg;

  // default internal level width
  localparam int LEVEL_BITS_DEF = 16;

  // width of time values (elapsed time, fade time, tick step)
  localparam int TIME_W = 32;

  // port widths of the level outputs, config data and index, and command
  localparam int OUT_LEVEL_W = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CMD_W       = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_TIME = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_READY = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE   = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_RESULT
  } state_t;

endpackage

### design/lfr_mul.sv
// ---------------------------------------------------------------------------
// lfr_mul
// Bit-serial shift-add multiplier: span times elapsed time, one bit of the
// span per cycle.
// ---------------------------------------------------------------------------
module lfr_mul #(
  parameter int LEVEL_BITS = lfr_pkg::LEVEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [LEVEL_BITS-1:0]                 span,
  input  logic [lfr_pkg::TIME_W-1:0]            elapsed,
  output logic                                  done,
  output logic [LEVEL_BITS+lfr_pkg::TIME_W-1:0] product
);

  localparam int TW = lfr_pkg::TIME_W;
  localparam int CW = $clog2(LEVEL_BITS + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [TW-1:0]     addend;
  logic [TW-1:0]     hi;
  logic [LEVEL_BITS-1:0] lo;
  logic [TW:0]       sum;

  // partial product add for the current span bit
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, addend} : {(TW+1){1'b0}});

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(LEVEL_BITS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    if (start) begin
      hi     <= '0;
      lo     <= span;
      addend <= elapsed;
    end else if (busy) begin
      {hi, lo} <= {sum, lo[LEVEL_BITS-1:1]};
    end
  end

  assign product = {hi, lo};

endmodule

### design/lfr_div.sv
// ---------------------------------------------------------------------------
// lfr_div
// Restoring divider, one quotient bit per cycle. The dividend's upper part
// is known to be below the divisor, so LEVEL_BITS steps give the quotient.
// ---------------------------------------------------------------------------
module lfr_div #(
  parameter int LEVEL_BITS = lfr_pkg::LEVEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [LEVEL_BITS+lfr_pkg::TIME_W-1:0] dividend,
  input  logic [lfr_pkg::TIME_W-1:0]            divisor,
  output logic                                  done,
  output logic [LEVEL_BITS-1:0]                 quotient
);

  localparam int TW = lfr_pkg::TIME_W;
  localparam int CW = $clog2(LEVEL_BITS + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [TW-1:0]         dvs;
  logic [TW-1:0]         rem;
  logic [LEVEL_BITS-1:0] quo;
  logic [TW:0]           trial;
  logic [TW:0]           diff;
  logic                  ge;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {rem, quo[LEVEL_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(LEVEL_BITS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[LEVEL_BITS+TW-1:LEVEL_BITS];
      quo <= dividend[LEVEL_BITS-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[TW-1:0] : trial[TW-1:0];
      quo <= {quo[LEVEL_BITS-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

### design/linear_fade_ramp.sv
// ---------------------------------------------------------------------------
// linear_fade_ramp
// Fade generator for one lighting channel: exact integer linear
// interpolation from start to target level over a fade time in ms.
// ---------------------------------------------------------------------------
// An interpolating tick passes from accept through the evaluate, multiply,
// divide and result states; a tick that needs no division goes from the
// evaluate state straight to the result state, and any other word goes
// straight to the result state. One word is in work at a time; the next is
// accepted in the cycle after the result loads, and the result waits in the
// output register meanwhile. Reset clears config, time, latch, level.
module linear_fade_ramp #(
  parameter int LEVEL_BITS = lfr_pkg::LEVEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // config write port
  input  logic                                 cfg_we,
  input  logic [lfr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lfr_pkg::CFG_DATA_W-1:0]       cfg_data,
  // command channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lfr_pkg::CMD_W-1:0]            command,
  input  logic [lfr_pkg::TIME_W-1:0]           time_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lfr_pkg::OUT_LEVEL_W-1:0]      level,
  output logic [7:0]                           level_low_byte,
  output logic                                 done_res
);

  localparam int TW = lfr_pkg::TIME_W;
  localparam int PW = LEVEL_BITS + TW;

  lfr_pkg::state_t state, state_next;

  logic [LEVEL_BITS-1:0] start_level;
  logic [LEVEL_BITS-1:0] target_level;
  logic [TW-1:0]         fade_duration;
  logic [TW-1:0]         elapsed_time;
  logic                  ready_latch;
  logic [LEVEL_BITS-1:0] cur_level;
  logic                  up;
  logic [LEVEL_BITS-1:0] span;

  logic                  accept;
  logic [TW:0]           time_sum;
  logic [TW-1:0]         time_sat;
  logic                  finish;
  logic                  up_now;
  logic                  mul_start;
  logic                  mul_done;
  logic [PW-1:0]         product;
  logic                  div_start;
  logic                  div_done;
  logic [LEVEL_BITS-1:0] move;
  logic                  out_load;

  assign accept = in_valid && in_ready;

  // saturating elapsed time update
  assign time_sum = {1'b0, elapsed_time} + {1'b0, time_value};
  assign time_sat = time_sum[TW] ? {TW{1'b1}} : time_sum[TW-1:0];

  // fade end test and direction
  assign finish = (elapsed_time >= fade_duration) || ready_latch;
  assign up_now = target_level > start_level;

  // distance between start and target
  assign span = up_now ? target_level - start_level : start_level - target_level;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lfr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (command == lfr_pkg::CMD_TICK) ? lfr_pkg::ST_EVAL
                                                      : lfr_pkg::ST_RESULT;
        end
      end
      lfr_pkg::ST_EVAL: begin
        if (finish || (elapsed_time == '0)) begin
          state_next = lfr_pkg::ST_RESULT;
        end else begin
          state_next = lfr_pkg::ST_MUL;
        end
      end
      lfr_pkg::ST_MUL: begin
        if (mul_done) begin
          state_next = lfr_pkg::ST_DIV;
        end
      end
      lfr_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = lfr_pkg::ST_RESULT;
        end
      end
      lfr_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = lfr_pkg::ST_IDLE;
        end
      end
      default: state_next = lfr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      lfr_pkg::ST_IDLE:   in_ready  = 1'b1;
      lfr_pkg::ST_EVAL:   mul_start = !finish && (elapsed_time != '0);
      lfr_pkg::ST_MUL:    div_start = mul_done;
      lfr_pkg::ST_DIV:    div_start = 1'b0;
      lfr_pkg::ST_RESULT: out_load  = !out_valid || out_ready;
      default:            in_ready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_level   <= '0;
      target_level  <= '0;
      fade_duration <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lfr_pkg::CFG_START:  start_level   <= LEVEL_BITS'(cfg_data[15:0]);
        lfr_pkg::CFG_TARGET: target_level  <= LEVEL_BITS'(cfg_data[15:0]);
        lfr_pkg::CFG_FADE:   fade_duration <= cfg_data[TW-1:0];
        default:             fade_duration <= fade_duration;
      endcase
    end
  end

  // fade state: elapsed time, ready latch, level
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_time <= '0;
      ready_latch  <= 1'b0;
      cur_level    <= '0;
    end else begin
      if (accept) begin
        case (command)
          lfr_pkg::CMD_TICK:      elapsed_time <= time_sat;
          lfr_pkg::CMD_LOAD_TIME: elapsed_time <= time_value;
          lfr_pkg::CMD_SET_READY: ready_latch  <= time_value[0];
          default:                ready_latch  <= ready_latch;
        endcase
      end
      if (state == lfr_pkg::ST_EVAL) begin
        if (finish) begin
          cur_level   <= target_level;
          ready_latch <= 1'b1;
        end else if (elapsed_time == '0) begin
          cur_level <= start_level;
        end
      end
      if ((state == lfr_pkg::ST_DIV) && div_done) begin
        cur_level <= up ? start_level + move : start_level - move;
      end
    end
  end

  // direction for the interpolation
  always_ff @(posedge clk) begin
    if (state == lfr_pkg::ST_EVAL) begin
      up <= up_now;
    end
  end

  lfr_mul #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .span    (span),
    .elapsed (elapsed_time),
    .done    (mul_done),
    .product (product)
  );

  lfr_div #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (fade_duration),
    .done     (div_done),
    .quotient (move)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      level          <= lfr_pkg::OUT_LEVEL_W'(cur_level);
      level_low_byte <= cur_level[7:0];
      done_res       <= ready_latch;
    end
  end

`ifndef SYNTHESIS
  // a finished fade lands on the target with the latch set
  a_finish_target: assert property (@(posedge clk) disable iff (rst)
    (state == lfr_pkg::ST_EVAL) && finish |=> ready_latch && (cur_level == target_level))
    else $error("finished fade did not land on target");

  // the multiplier only reports while the controller waits on it
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == lfr_pkg::ST_MUL))
    else $error("multiplier done outside multiply state");

  // the divider only reports while the controller waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == lfr_pkg::ST_DIV))
    else $error("divider done outside divide state");

  // an interpolated level on a rising fade does not pass the target
  a_interp_range: assert property (@(posedge clk) disable iff (rst)
    (state == lfr_pkg::ST_DIV) && div_done && up |=> (cur_level <= target_level))
    else $error("interpolated level overshoots target");
`endif

endmodule
